FILE: hdl/cfpa_pkg.sv
// Package for the complex fixed-point ALU: item types, opcodes, CORDIC angle table.
// Used by complex_fixed_point_alu_unit; depends on nothing.
`default_nettype none

package cfpa_pkg;

	localparam int DATA_W    = 16;
	localparam int FRAC_BITS = 12;
	localparam int ANG_FRAC  = 30;
	localparam int GUARD_SH  = 16;
	localparam int WIDE_W    = 40;
	localparam int CX_W      = 36;
	localparam int CZ_W      = 35;
	localparam int SQ_W      = 2 * DATA_W;
	localparam int SQRT_STEPS = DATA_W;

	typedef enum logic [2:0] {
		OP_ADD   = 3'd0,
		OP_SUB   = 3'd1,
		OP_MUL   = 3'd2,
		OP_CONJ  = 3'd3,
		OP_SCALE = 3'd4,
		OP_EQ    = 3'd5,
		OP_POLAR = 3'd6
	} op_code_t;

	localparam logic [2:0] OP_UNUSED = 3'd7;

	typedef struct packed {
		logic [2:0]               opcode;
		logic signed [DATA_W-1:0] a_real;
		logic signed [DATA_W-1:0] a_imag;
		logic signed [DATA_W-1:0] b_real;
		logic signed [DATA_W-1:0] b_imag;
	} cmd_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] res_real;
		logic signed [DATA_W-1:0] res_imag;
		logic                     is_equal;
		logic                     overflow;
	} rsp_t;

	typedef struct packed {
		logic                     ov;
		logic signed [DATA_W-1:0] val;
	} sat_t;

	// payload of one item inside the iteration pipe
	typedef struct packed {
		logic [2:0]               op;
		logic signed [DATA_W-1:0] rr;
		logic signed [DATA_W-1:0] ri;
		logic                     eq;
		logic                     ov;
		logic                     zero;
		logic signed [CX_W-1:0]   cx;
		logic signed [CX_W-1:0]   cy;
		logic signed [CZ_W-1:0]   cz;
		logic [SQ_W-1:0]          sn;
		logic [SQ_W-1:0]          sr;
	} iter_t;

	localparam logic signed [CZ_W-1:0] PI_Q30 = 35'sd3373259426;

	localparam logic [30:0] ATAN_Q30 [0:31] = '{
		31'd843314857, 31'd497837829, 31'd263043837, 31'd133525159, 31'd67021688,
		31'd33543516, 31'd16775851, 31'd8388437, 31'd4194283, 31'd2097149,
		31'd1048576, 31'd524288, 31'd262144, 31'd131072, 31'd65536, 31'd32768,
		31'd16384, 31'd8192, 31'd4096, 31'd2048, 31'd1024, 31'd512, 31'd256,
		31'd128, 31'd64, 31'd32, 31'd16, 31'd8, 31'd4, 31'd2, 31'd1, 31'd0
	};

	// clamp a wide signed value to the data word
	function automatic sat_t sat_word(input logic signed [WIDE_W-1:0] v);
		sat_t r;
		localparam logic signed [WIDE_W-1:0] HI = (WIDE_W'(1) <<< (DATA_W - 1)) - 1;
		localparam logic signed [WIDE_W-1:0] LO = -HI - 1;
		if (v > HI) begin
			r.ov  = 1'b1;
			r.val = HI[DATA_W-1:0];
		end else if (v < LO) begin
			r.ov  = 1'b1;
			r.val = LO[DATA_W-1:0];
		end else begin
			r.ov  = 1'b0;
			r.val = v[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/complex_fixed_point_alu_unit.sv
// Complex fixed-point ALU, top level: add, sub, mul, conj, scale, equals, polar form.
// Depends on cfpa_pkg (types, opcode codes, CORDIC angle table, saturation).
// Pipeline: an operand and product stage, a setup stage, one iteration stage per step of the
//   longer of CORDIC_STEPS and the magnitude square root, then the output register. The root
//   yields one result bit per stage; the phase uses one CORDIC step per stage alongside it.
// Throughput: one item per cycle; busy stays low, the receiver cannot stall.
// Reset: arst_n clears the valid bits only; payload registers are not reset.
`default_nettype none

module complex_fixed_point_alu_unit #(
	parameter int CORDIC_STEPS = 16
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             start,
	output logic            busy,
	input  cfpa_pkg::cmd_t  operands,
	output logic            done,
	output cfpa_pkg::rsp_t  result
);

	localparam int DW     = cfpa_pkg::DATA_W;
	localparam int WW     = cfpa_pkg::WIDE_W;
	localparam int XW     = cfpa_pkg::CX_W;
	localparam int ZW     = cfpa_pkg::CZ_W;
	localparam int NW     = cfpa_pkg::SQ_W;
	localparam int SQS    = cfpa_pkg::SQRT_STEPS;
	localparam int FB     = cfpa_pkg::FRAC_BITS;
	localparam int ITERS  = (CORDIC_STEPS > SQS) ? CORDIC_STEPS : SQS;
	localparam int LAT    = ITERS + 3;
	localparam int PH_SH  = cfpa_pkg::ANG_FRAC - FB;
	localparam logic signed [WW-1:0] HALF_P  = WW'(1) <<< (FB - 1);
	localparam logic signed [WW-1:0] HALF_PH = WW'(1) <<< (PH_SH - 1);

	// the pipe never refuses an item
	assign busy = 1'b0;

	// ---------------- stage 1: operands and products ----------------
	logic                   vld_s1;
	logic [2:0]             op_s1;
	logic signed [DW-1:0]   ar_s1, ai_s1, br_s1, bi_s1;
	logic signed [2*DW-1:0] prr_s1, pii_s1, pri_s1, pir_s1;
	logic [NW-1:0]          sqx_s1, sqy_s1;
	logic [DW-1:0]          ux, uy;

	assign ux = operands.a_real[DW-1] ? DW'(-operands.a_real) : operands.a_real;
	assign uy = operands.a_imag[DW-1] ? DW'(-operands.a_imag) : operands.a_imag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		op_s1  <= operands.opcode;
		ar_s1  <= operands.a_real;
		ai_s1  <= operands.a_imag;
		br_s1  <= operands.b_real;
		bi_s1  <= operands.b_imag;
		prr_s1 <= operands.a_real * operands.b_real;
		pii_s1 <= operands.a_imag * operands.b_imag;
		pri_s1 <= operands.a_real * operands.b_imag;
		pir_s1 <= operands.a_imag * operands.b_real;
		sqx_s1 <= ux * ux;
		sqy_s1 <= uy * uy;
	end

	// ---------------- stage 2: plain results, CORDIC and root setup ----------------
	// itr_s[0] is stage 2; itr_s[k+1] holds the item after iteration k
	logic             itr_vld_s [0:ITERS];
	cfpa_pkg::iter_t  itr_s     [0:ITERS];
	cfpa_pkg::iter_t  s2_nxt;

	always_comb begin
		logic signed [WW-1:0] w_r, w_i;
		cfpa_pkg::sat_t sr_r, sr_i;
		logic signed [XW-1:0] x0, y0;
		w_r = '0;
		w_i = '0;
		unique case (op_s1)
			cfpa_pkg::OP_ADD: begin
				w_r = WW'(ar_s1) + WW'(br_s1);
				w_i = WW'(ai_s1) + WW'(bi_s1);
			end
			cfpa_pkg::OP_SUB: begin
				w_r = WW'(ar_s1) - WW'(br_s1);
				w_i = WW'(ai_s1) - WW'(bi_s1);
			end
			cfpa_pkg::OP_MUL: begin
				w_r = (WW'(prr_s1) - WW'(pii_s1) + HALF_P) >>> FB;
				w_i = (WW'(pri_s1) + WW'(pir_s1) + HALF_P) >>> FB;
			end
			cfpa_pkg::OP_CONJ: begin
				w_r = WW'(ar_s1);
				w_i = -WW'(ai_s1);
			end
			cfpa_pkg::OP_SCALE: begin
				w_r = (WW'(prr_s1) + HALF_P) >>> FB;
				w_i = (WW'(pir_s1) + HALF_P) >>> FB;
			end
			default: begin
				w_r = '0;
				w_i = '0;
			end
		endcase
		sr_r = cfpa_pkg::sat_word(w_r);
		sr_i = cfpa_pkg::sat_word(w_i);

		s2_nxt.op   = op_s1;
		s2_nxt.rr   = sr_r.val;
		s2_nxt.ri   = sr_i.val;
		s2_nxt.ov   = sr_r.ov | sr_i.ov;
		s2_nxt.eq   = (op_s1 == cfpa_pkg::OP_EQ) && (ar_s1 == br_s1) && (ai_s1 == bi_s1);
		s2_nxt.zero = (ar_s1 == '0) && (ai_s1 == '0);

		// operands carry 16 guard bits; left half plane is folded by a pi rotation
		x0 = {{(XW-DW-cfpa_pkg::GUARD_SH){ar_s1[DW-1]}}, ar_s1, {cfpa_pkg::GUARD_SH{1'b0}}};
		y0 = {{(XW-DW-cfpa_pkg::GUARD_SH){ai_s1[DW-1]}}, ai_s1, {cfpa_pkg::GUARD_SH{1'b0}}};
		if (ar_s1[DW-1]) begin
			s2_nxt.cx = -x0;
			s2_nxt.cy = -y0;
			s2_nxt.cz = ai_s1[DW-1] ? -cfpa_pkg::PI_Q30 : cfpa_pkg::PI_Q30;
		end else begin
			s2_nxt.cx = x0;
			s2_nxt.cy = y0;
			s2_nxt.cz = '0;
		end
		s2_nxt.sn = sqx_s1 + sqy_s1;
		s2_nxt.sr = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			itr_vld_s[0] <= 1'b0;
		end else begin
			itr_vld_s[0] <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		itr_s[0] <= s2_nxt;
	end

	// ---------------- iteration stages: up to one CORDIC step and one root bit each ----------------
	for (genvar k = 0; k < ITERS; k++) begin : g_iter
		localparam int BSH = (k < SQS) ? 2 * (SQS - 1 - k) : 0;
		localparam int AIX = (k < 32) ? k : 31;
		localparam logic [NW-1:0] RBIT = NW'(1) << BSH;
		cfpa_pkg::iter_t nxt;
		logic signed [XW-1:0] xs, ys;
		logic [NW-1:0] trial;

		assign xs    = itr_s[k].cx >>> k;
		assign ys    = itr_s[k].cy >>> k;
		assign trial = itr_s[k].sr + RBIT;

		always_comb begin
			nxt = itr_s[k];
			if (k < CORDIC_STEPS) begin
				if (!itr_s[k].cy[XW-1]) begin
					nxt.cx = itr_s[k].cx + ys;
					nxt.cy = itr_s[k].cy - xs;
					nxt.cz = itr_s[k].cz + ZW'(cfpa_pkg::ATAN_Q30[AIX]);
				end else begin
					nxt.cx = itr_s[k].cx - ys;
					nxt.cy = itr_s[k].cy + xs;
					nxt.cz = itr_s[k].cz - ZW'(cfpa_pkg::ATAN_Q30[AIX]);
				end
			end
			if (k < SQS) begin
				if (itr_s[k].sn >= trial) begin
					nxt.sn = itr_s[k].sn - trial;
					nxt.sr = (itr_s[k].sr >> 1) + RBIT;
				end else begin
					nxt.sr = itr_s[k].sr >> 1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				itr_vld_s[k+1] <= 1'b0;
			end else begin
				itr_vld_s[k+1] <= itr_vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			itr_s[k+1] <= nxt;
		end
	end

	// ---------------- output stage: root rounding, phase rounding, saturation ----------------
	cfpa_pkg::rsp_t out_nxt;

	always_comb begin
		logic [NW-1:0] mag;
		logic signed [WW-1:0] ph;
		cfpa_pkg::sat_t sm, sp;
		mag = itr_s[ITERS].sr + NW'(itr_s[ITERS].sn > itr_s[ITERS].sr);
		// both arms signed so the shift stays arithmetic
		ph  = itr_s[ITERS].zero ? WW'(0) : ((WW'(itr_s[ITERS].cz) + HALF_PH) >>> PH_SH);
		sm  = cfpa_pkg::sat_word(WW'(mag));
		sp  = cfpa_pkg::sat_word(ph);
		if (itr_s[ITERS].op == cfpa_pkg::OP_POLAR) begin
			out_nxt.res_real = sm.val;
			out_nxt.res_imag = sp.val;
			out_nxt.is_equal = 1'b0;
			out_nxt.overflow = sm.ov | sp.ov;
		end else begin
			out_nxt.res_real = itr_s[ITERS].rr;
			out_nxt.res_imag = itr_s[ITERS].ri;
			out_nxt.is_equal = itr_s[ITERS].eq;
			out_nxt.overflow = itr_s[ITERS].ov;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= itr_vld_s[ITERS];
		end
	end

	always_ff @(posedge clk) begin
		result <= out_nxt;
	end

`ifndef NO_ASSERTIONS
	// every accepted item comes out after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("item did not emerge after pipeline latency");

	// an equal flag only comes with a clean zero payload
	a_eq_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.is_equal) |->
		(!result.overflow && result.res_real == '0 && result.res_imag == '0))
		else $error("equal flag with nonzero payload");

	// the unused opcode yields an all-zero result
	a_unused: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && operands.opcode == cfpa_pkg::OP_UNUSED) |->
		##LAT (done && result == '0))
		else $error("unused opcode gave nonzero result");
`endif

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Testbench for complex_fixed_point_alu_unit: a directed table, then random items, each result
// checked against a typed-in value or a bit-exact predictor. Depends on cfpa_pkg and the unit under test.
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_RANDOM   = 2000;
	localparam int TAIL_WAIT  = 40;      // extra wait after the last owed result
	localparam int CYCLE_LIMIT = 200000;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             start;
	logic             busy;
	cfpa_pkg::cmd_t   operands;
	logic             done;
	cfpa_pkg::rsp_t   result;

	complex_fixed_point_alu_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.operands (operands),
		.done     (done),
		.result   (result)
	);

	always #4 clk = ~clk;

	// results still owed by the unit, oldest first
	cfpa_pkg::rsp_t pending_rsp[$];
	int   mismatches = 0;
	int   cycles = 0;

	// ---------------- predictor ----------------
	function automatic longint clamp_word(input longint v, inout logic ov);
		if (v > 32767) begin
			ov = 1'b1;
			return 32767;
		end
		if (v < -32768) begin
			ov = 1'b1;
			return -32768;
		end
		return v;
	endfunction

	// v / 2^s, nearest, ties toward plus infinity
	function automatic longint round_shift(input longint v, input int s);
		longint q;
		longint rem;
		q = v >>> s;
		rem = v - (q <<< s);
		if (rem >= (longint'(1) <<< (s - 1)))
			q++;
		return q;
	endfunction

	function automatic longint root_nearest(input longint unsigned n);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		if (n > r)
			r++;
		return longint'(r);
	endfunction

	// phase of (re, im) in Q2.30 radians
	function automatic longint phase_q30(input longint re, input longint im);
		longint x;
		longint y;
		longint z;
		longint xs;
		longint ys;
		x = re * 65536;
		y = im * 65536;
		z = 0;
		if (re == 0 && im == 0)
			return 0;
		// left half plane: turn by pi first
		if (x < 0) begin
			z = (y >= 0) ? longint'(cfpa_pkg::PI_Q30) : -longint'(cfpa_pkg::PI_Q30);
			x = -x;
			y = -y;
		end
		for (int i = 0; i < 16; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z += longint'(cfpa_pkg::ATAN_Q30[i]);
			end else begin
				x = x - ys;
				y = y + xs;
				z -= longint'(cfpa_pkg::ATAN_Q30[i]);
			end
		end
		return z;
	endfunction

	function automatic cfpa_pkg::rsp_t alu_predict(input cfpa_pkg::cmd_t c);
		cfpa_pkg::rsp_t r;
		longint ar;
		longint ai;
		longint br;
		longint bi;
		longint rr;
		longint ri;
		logic   ov;
		ar = c.a_real;
		ai = c.a_imag;
		br = c.b_real;
		bi = c.b_imag;
		rr = 0;
		ri = 0;
		ov = 1'b0;
		r  = '0;
		case (c.opcode)
			cfpa_pkg::OP_ADD: begin
				rr = clamp_word(ar + br, ov);
				ri = clamp_word(ai + bi, ov);
			end
			cfpa_pkg::OP_SUB: begin
				rr = clamp_word(ar - br, ov);
				ri = clamp_word(ai - bi, ov);
			end
			cfpa_pkg::OP_MUL: begin
				rr = clamp_word(round_shift(ar * br - ai * bi, cfpa_pkg::FRAC_BITS), ov);
				ri = clamp_word(round_shift(ar * bi + ai * br, cfpa_pkg::FRAC_BITS), ov);
			end
			cfpa_pkg::OP_CONJ: begin
				rr = ar;
				ri = clamp_word(-ai, ov);
			end
			cfpa_pkg::OP_SCALE: begin
				rr = clamp_word(round_shift(ar * br, cfpa_pkg::FRAC_BITS), ov);
				ri = clamp_word(round_shift(ai * br, cfpa_pkg::FRAC_BITS), ov);
			end
			cfpa_pkg::OP_EQ: r.is_equal = (ar == br) && (ai == bi);
			cfpa_pkg::OP_POLAR: begin
				rr = clamp_word(root_nearest(longint'(ar * ar + ai * ai)), ov);
				ri = clamp_word(round_shift(phase_q30(ar, ai),
					cfpa_pkg::ANG_FRAC - cfpa_pkg::FRAC_BITS), ov);
			end
			default: ;  // unused code seven: all zero
		endcase
		r.res_real = rr[15:0];
		r.res_imag = ri[15:0];
		r.overflow = ov;
		return r;
	endfunction

	// ---------------- directed table ----------------
	typedef struct {
		cfpa_pkg::cmd_t c;
		bit             typed;   // expected value below is typed in
		cfpa_pkg::rsp_t r;
	} vector_t;

	vector_t vectors[$];

	function automatic cfpa_pkg::cmd_t mk(input logic [2:0] op, input int ar, input int ai,
	                                      input int br, input int bi);
		cfpa_pkg::cmd_t c;
		c.opcode = op;
		c.a_real = ar[15:0];
		c.a_imag = ai[15:0];
		c.b_real = br[15:0];
		c.b_imag = bi[15:0];
		return c;
	endfunction

	function automatic cfpa_pkg::rsp_t mr(input int rr, input int ri, input bit eq,
	                                      input bit ov);
		cfpa_pkg::rsp_t r;
		r.res_real = rr[15:0];
		r.res_imag = ri[15:0];
		r.is_equal = eq;
		r.overflow = ov;
		return r;
	endfunction

	task automatic add_vec(input cfpa_pkg::cmd_t c, input bit typed, input cfpa_pkg::rsp_t r);
		vector_t v;
		v.c = c;
		v.typed = typed;
		v.r = r;
		vectors.push_back(v);
	endtask

	task automatic build_table();
		cfpa_pkg::rsp_t z;
		z = '0;
		add_vec(mk(cfpa_pkg::OP_ADD, 0, 0, 0, 0), 1, mr(0, 0, 0, 0));
		add_vec(mk(cfpa_pkg::OP_ADD, 32767, -32768, 1, -1), 1, mr(32767, -32768, 0, 1));
		add_vec(mk(cfpa_pkg::OP_SUB, -32768, 32767, 1, -1), 1, mr(-32768, 32767, 0, 1));
		add_vec(mk(cfpa_pkg::OP_SUB, 100, -7, 30, 5), 1, mr(70, -12, 0, 0));
		add_vec(mk(cfpa_pkg::OP_MUL, -32768, -32768, -32768, -32768), 0, z);
		add_vec(mk(cfpa_pkg::OP_MUL, 32767, 32767, 32767, -32768), 0, z);
		add_vec(mk(cfpa_pkg::OP_MUL, 4096, 0, 1234, -999), 1, mr(1234, -999, 0, 0));
		add_vec(mk(cfpa_pkg::OP_MUL, 1, 1, 2048, 2048), 0, z);   // real products cancel, imaginary sum is exact
		add_vec(mk(cfpa_pkg::OP_CONJ, -32768, -32768, 5, 5), 1, mr(-32768, 32767, 0, 1));
		add_vec(mk(cfpa_pkg::OP_CONJ, 32767, 32767, 0, 0), 1, mr(32767, -32767, 0, 0));
		add_vec(mk(cfpa_pkg::OP_SCALE, -32768, 32767, -32768, 77), 0, z);
		add_vec(mk(cfpa_pkg::OP_SCALE, 3, -3, 2048, 0), 0, z);
		add_vec(mk(cfpa_pkg::OP_EQ, -32768, 32767, -32768, 32767), 1, mr(0, 0, 1, 0));
		add_vec(mk(cfpa_pkg::OP_EQ, 5, 6, 5, 7), 1, mr(0, 0, 0, 0));
		add_vec(mk(cfpa_pkg::OP_POLAR, 0, 0, 9, 9), 1, mr(0, 0, 0, 0));
		add_vec(mk(cfpa_pkg::OP_POLAR, -32768, -32768, 0, 0), 0, z);
		add_vec(mk(cfpa_pkg::OP_POLAR, 32767, 32767, 0, 0), 0, z);
		add_vec(mk(cfpa_pkg::OP_POLAR, -4096, 0, 0, 0), 0, z);   // on the negative real axis
		add_vec(mk(cfpa_pkg::OP_POLAR, -4096, -1, 0, 0), 0, z);
		add_vec(mk(cfpa_pkg::OP_POLAR, 0, -4096, 0, 0), 0, z);
		add_vec(mk(cfpa_pkg::OP_UNUSED, -1, -1, -1, -1), 1, mr(0, 0, 0, 0));
	endtask

	// operand word biased toward the edges of the range and toward small values
	function automatic logic [15:0] pick_word();
		case ($urandom_range(7))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'(int'($urandom_range(16)) - 8);
			3: return 16'($urandom_range(8191) - 4096);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic cfpa_pkg::cmd_t random_cmd();
		cfpa_pkg::cmd_t c;
		c.opcode = 3'($urandom_range(7));
		c.a_real = pick_word();
		c.a_imag = pick_word();
		c.b_real = pick_word();
		c.b_imag = pick_word();
		// equals needs hits too
		if (c.opcode == cfpa_pkg::OP_EQ && $urandom_range(1)) begin
			c.b_real = c.a_real;
			if ($urandom_range(3) != 0)
				c.b_imag = c.a_imag;
		end
		return c;
	endfunction

	// present one item, hold until taken, then log what the unit owes
	task automatic issue(input cfpa_pkg::cmd_t c, input bit typed, input cfpa_pkg::rsp_t r,
	                     input int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start    <= 1'b1;
		operands <= c;
		do
			@(posedge clk);
		while (busy);
		pending_rsp.push_back(typed ? r : alu_predict(c));
	endtask

	// ---------------- result checker ----------------
	always @(posedge clk) begin
		cfpa_pkg::rsp_t want;
		if (arst_n && done) begin
			if (pending_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", result);
			end else begin
				want = pending_rsp.pop_front();
				if (result.res_real !== want.res_real || result.res_imag !== want.res_imag ||
				    result.is_equal !== want.is_equal || result.overflow !== want.overflow) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: re %0d/%0d im %0d/%0d eq %b/%b ov %b/%b (exp/got)",
							want.res_real, result.res_real, want.res_imag, result.res_imag,
							want.is_equal, result.is_equal, want.overflow, result.overflow);
				end
			end
		end
	end

	// ---------------- watchdog ----------------
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// ---------------- stimulus ----------------
	initial begin
		int phase_pct[4];
		cfpa_pkg::rsp_t none;
		none = '0;
		phase_pct = '{0, 61, 0, 7};
		arst_n   = 1'b0;
		start    = 1'b0;
		operands = '0;
		build_table();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (vectors[i])
			issue(vectors[i].c, vectors[i].typed, vectors[i].r, (i % 3 == 0) ? 50 : 0);

		for (int i = 0; i < N_RANDOM; i++)
			issue(random_cmd(), 1'b0, none, phase_pct[(i * 4) / N_RANDOM]);
		start <= 1'b0;

		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);

		if (mismatches == 0 && pending_rsp.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire
